// ===== src/gbn_pkg.sv =====
package gbn_pkg;

  // Frame index width and sizes of the counters carried in result beats
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned WIN_W     = 6;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned TIMER_W   = 17;
  localparam int unsigned XMIT_W    = 32;
  localparam int unsigned TOCNT_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Largest window the sender keeps outstanding
  localparam int unsigned GBN_MAX_WINDOW = 32;

  // Register values after reset
  localparam logic [WIN_W-1:0]     WINDOW_RST  = WIN_W'(4);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(200);
  localparam logic [IDX_W-1:0]     TOTAL_RST   = '0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE   = 2'd0,
    CFG_TIMEOUT_TICKS = 2'd1,
    CFG_FRAME_TOTAL   = 2'd2
  } cfg_idx_t;

  // Input event kinds
  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_ACK  = 1'b1
  } func_t;

  // Result beat kinds
  typedef enum logic [1:0] {
    KIND_NEW    = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_EOF    = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_CHECK,
    S_RESEND,
    S_STATUS
  } state_t;

endpackage

// ===== src/gbn_ifs.sv =====
interface gbn_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [gbn_pkg::IDX_W-1:0] ack_number;
  logic                      ack_check_ok;

  modport source (output valid, func, ack_number, ack_check_ok, input ready);
  modport sink   (input valid, func, ack_number, ack_check_ok, output ready);
endinterface

interface gbn_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  item_kind;
  logic [gbn_pkg::IDX_W-1:0]   frame_index;
  logic [gbn_pkg::IDX_W-1:0]   window_base;
  logic [gbn_pkg::IDX_W-1:0]   next_to_send;
  logic [gbn_pkg::IDX_W-1:0]   newly_acked;
  logic [gbn_pkg::XMIT_W-1:0]  transmit_total;
  logic [gbn_pkg::TOCNT_W-1:0] timeout_total;
  logic                        all_done;
  logic                        last_of_run;

  modport source (output valid, item_kind, frame_index, window_base, next_to_send,
                  newly_acked, transmit_total, timeout_total, all_done, last_of_run,
                  input ready);
  modport sink   (input valid, item_kind, frame_index, window_base, next_to_send,
                  newly_acked, transmit_total, timeout_total, all_done, last_of_run,
                  output ready);
endinterface

// ===== src/go_back_n_sender_window.sv =====
// Go-Back-N sender window control. Each input beat is a poll tick or a received
// cumulative ACK; each produces one or more result beats, the final one flagged
// by last_of_run. An ACK, or a tick that only ends the transfer or finds it
// already finished, is accepted and then yields its single beat. A tick that
// sends is accepted and then yields one new frame beat after another, ending
// on the last one when the timer does not expire. When the window is resent, or
// nothing new is sent, the send pass ends on an idle step and the timeout check
// follows before the resend beats; a tick that sends and resends nothing ends on
// one status beat. The input is not ready meanwhile. The single sequencer emits
// one beat per cycle through the result register while the sink is ready, and
// a beat waits while the sink holds ready low.
// Configuration is to be written through cfg_we/cfg_index/cfg_wdata while idle;
// the user is bound by this, and the block itself does not enforce it.
module go_back_n_sender_window #(
  parameter int unsigned MAX_WINDOW = gbn_pkg::GBN_MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  gbn_in_if.sink                           in_if,
  gbn_out_if.source                        out_if
);
  import gbn_pkg::*;

  localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(MAX_WINDOW);
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Configuration registers
  logic [WIN_W-1:0]     window_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [IDX_W-1:0]     total_r;

  // Window state
  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     base_r, base_nxt;
  logic [IDX_W-1:0]     next_r, next_nxt;
  logic [TIMER_W-1:0]   timer_r, timer_nxt;
  logic                 finished_r, finished_nxt;
  logic [XMIT_W-1:0]    xmit_r, xmit_nxt;
  logic [TOCNT_W-1:0]   tocnt_r, tocnt_nxt;
  logic [IDX_W-1:0]     res_idx_r, res_idx_nxt;
  logic [IDX_W-1:0]     acked_r, acked_nxt;
  kind_t                kind_r, kind_nxt;

  // Result register
  logic                 out_valid_r;
  kind_t                o_kind_r;
  logic [IDX_W-1:0]     o_frame_r, o_base_r, o_next_r, o_acked_r;
  logic [XMIT_W-1:0]    o_xmit_r;
  logic [TOCNT_W-1:0]   o_tocnt_r;
  logic                 o_done_r, o_last_r;

  // Beat produced by the sequencer this cycle
  logic                 emit;
  kind_t                e_kind;
  logic [IDX_W-1:0]     e_frame;
  logic [IDX_W-1:0]     e_acked;
  logic                 e_last;

  logic                 in_fire, out_free;
  logic [WIN_W-1:0]     win_eff;
  logic [IDX_W:0]       win_limit;
  logic [IDX_W-1:0]     next_inc;
  logic                 can_send, more_after;
  logic [TIMER_W-1:0]   timer_after;
  logic                 to_after, timed_out;
  logic [XMIT_W-1:0]    xmit_inc;
  logic                 ack_good;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // Window limit and lookahead for the send loop
  assign win_eff     = (window_r > WIN_CAP) ? WIN_CAP : window_r;
  assign win_limit   = {1'b0, base_r} + {{(IDX_W+1-WIN_W){1'b0}}, win_eff};
  assign next_inc    = next_r + IDX_W'(1);
  assign can_send    = ({1'b0, next_r} < win_limit) && (next_r < total_r);
  assign more_after  = ({1'b0, next_inc} < win_limit) && (next_inc < total_r);
  assign timer_after = (base_r == next_r) ? '0 : timer_r;
  assign to_after    = timer_after > {{(TIMER_W-TIMEOUT_W){1'b0}}, timeout_r};
  assign timed_out   = timer_r > {{(TIMER_W-TIMEOUT_W){1'b0}}, timeout_r};
  assign xmit_inc    = (xmit_r == '1) ? xmit_r : xmit_r + XMIT_W'(1);
  assign ack_good    = !finished_r && in_if.ack_check_ok &&
                       (in_if.ack_number > base_r) && (in_if.ack_number <= total_r);

  // Sequencer: next state, window updates and the beat to emit
  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    next_nxt     = next_r;
    timer_nxt    = timer_r;
    finished_nxt = finished_r;
    xmit_nxt     = xmit_r;
    tocnt_nxt    = tocnt_r;
    res_idx_nxt  = res_idx_r;
    acked_nxt    = acked_r;
    kind_nxt     = kind_r;
    emit         = 1'b0;
    e_kind       = KIND_STATUS;
    e_frame      = '0;
    e_acked      = '0;
    e_last       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          acked_nxt = '0;
          kind_nxt  = KIND_STATUS;
          priority if (in_if.func == FUNC_ACK) begin
            // take a good cumulative ACK, pull next up behind base
            if (ack_good) begin
              acked_nxt = in_if.ack_number - base_r;
              base_nxt  = in_if.ack_number;
              if (next_r < in_if.ack_number) begin
                next_nxt = in_if.ack_number;
              end
            end
            state_nxt = S_STATUS;
          end else if (finished_r) begin
            state_nxt = S_STATUS;
          end else if (base_r >= total_r) begin
            finished_nxt = 1'b1;
            kind_nxt     = KIND_EOF;
            state_nxt    = S_STATUS;
          end else begin
            // advance the retransmit timer, then fill the window
            if (timer_r != TIMER_MAX) begin
              timer_nxt = timer_r + TIMER_W'(1);
            end
            state_nxt = S_SEND;
          end
        end
      end

      S_SEND: begin
        if (!can_send) begin
          state_nxt = S_CHECK;
        end else if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_NEW;
          e_frame   = next_r;
          e_last    = !more_after && !to_after;
          xmit_nxt  = xmit_inc;
          timer_nxt = timer_after;
          next_nxt  = next_inc;
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_CHECK: begin
        // count a timeout and resend the outstanding frames
        if (timed_out) begin
          tocnt_nxt = (tocnt_r == '1) ? tocnt_r : tocnt_r + TOCNT_W'(1);
          timer_nxt = '0;
          if (next_r > base_r) begin
            res_idx_nxt = base_r;
            state_nxt   = S_RESEND;
          end else begin
            state_nxt = S_STATUS;
          end
        end else begin
          state_nxt = S_STATUS;
        end
      end

      S_RESEND: begin
        if (out_free) begin
          emit        = 1'b1;
          e_kind      = KIND_RESEND;
          e_frame     = res_idx_r;
          e_last      = (res_idx_r + IDX_W'(1)) == next_r;
          xmit_nxt    = xmit_inc;
          res_idx_nxt = res_idx_r + IDX_W'(1);
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_STATUS: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = kind_r;
          e_acked   = acked_r;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RST;
      timeout_r   <= TIMEOUT_RST;
      total_r     <= TOTAL_RST;
      state_r     <= S_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      timer_r     <= '0;
      finished_r  <= 1'b0;
      xmit_r      <= '0;
      tocnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WINDOW_SIZE:   window_r  <= cfg_wdata[WIN_W-1:0];
          CFG_TIMEOUT_TICKS: timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
          CFG_FRAME_TOTAL:   total_r   <= cfg_wdata[IDX_W-1:0];
          default: ;
        endcase
      end
      state_r    <= state_nxt;
      base_r     <= base_nxt;
      next_r     <= next_nxt;
      timer_r    <= timer_nxt;
      finished_r <= finished_nxt;
      xmit_r     <= xmit_nxt;
      tocnt_r    <= tocnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold per-run scratch values
  always_ff @(posedge clk) begin
    res_idx_r <= res_idx_nxt;
    acked_r   <= acked_nxt;
    kind_r    <= kind_nxt;
  end

  // Load the result register with the state after this beat
  always_ff @(posedge clk) begin
    if (emit) begin
      o_kind_r  <= e_kind;
      o_frame_r <= e_frame;
      o_base_r  <= base_nxt;
      o_next_r  <= next_nxt;
      o_acked_r <= e_acked;
      o_xmit_r  <= xmit_nxt;
      o_tocnt_r <= tocnt_nxt;
      o_done_r  <= finished_nxt;
      o_last_r  <= e_last;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.item_kind      = o_kind_r;
  assign out_if.frame_index    = o_frame_r;
  assign out_if.window_base    = o_base_r;
  assign out_if.next_to_send   = o_next_r;
  assign out_if.newly_acked    = o_acked_r;
  assign out_if.transmit_total = o_xmit_r;
  assign out_if.timeout_total  = o_tocnt_r;
  assign out_if.all_done       = o_done_r;
  assign out_if.last_of_run    = o_last_r;

endmodule

// ===== tb/go_back_n_sender_window_test.sv =====
`timescale 1ns / 1ps

package gbn_tb_pkg;
  import gbn_pkg::*;

  localparam int unsigned TIMER_SAT = (1 << TIMER_W) - 1;

  // One result beat as seen on the output channel
  typedef struct {
    kind_t              kind;
    logic [IDX_W-1:0]   frame;
    logic [IDX_W-1:0]   base;
    logic [IDX_W-1:0]   next;
    logic [IDX_W-1:0]   acked;
    logic [XMIT_W-1:0]  xmits;
    logic [TOCNT_W-1:0] touts;
    logic               done;
    logic               last;
  } beat_t;

  // Tracks the sender window and queues the beats each event must produce
  class arq_window_tracker;
    int unsigned       win_cfg;
    int unsigned       timeout_ticks;
    int unsigned       frame_total;
    int unsigned       base_idx;
    int unsigned       next_idx;
    int unsigned       timer;
    int unsigned       touts;
    logic [XMIT_W-1:0] xmits;
    bit                finished;
    beat_t             due_beats[$];
    beat_t             run_beats[$];
    int unsigned       failures;

    function new();
      win_cfg       = WINDOW_RST;
      timeout_ticks = TIMEOUT_RST;
      frame_total   = TOTAL_RST;
      base_idx      = 0;
      next_idx      = 0;
      timer         = 0;
      touts         = 0;
      xmits         = '0;
      finished      = 1'b0;
      failures      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_WINDOW_SIZE:   win_cfg = value[WIN_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks = value[TIMEOUT_W-1:0];
        CFG_FRAME_TOTAL:   frame_total = value[IDX_W-1:0];
        default: ;
      endcase
    endfunction

    // Capture the state as it stands after this beat
    function void emit_beat(kind_t kind, int unsigned frame, int unsigned acked);
      beat_t b;
      if (run_beats.size() >= 2 * GBN_MAX_WINDOW) return;
      b.kind  = kind;
      b.frame = IDX_W'(frame);
      b.base  = IDX_W'(base_idx);
      b.next  = IDX_W'(next_idx);
      b.acked = IDX_W'(acked);
      b.xmits = xmits;
      b.touts = TOCNT_W'(touts);
      b.done  = finished;
      b.last  = 1'b0;
      run_beats.insert(run_beats.size(), b);
    endfunction

    function void count_xmit();
      if (xmits != '1) xmits++;
    endfunction

    function void accept_event(func_t func, logic [IDX_W-1:0] ack, logic ok);
      int unsigned win;
      int unsigned acked;
      run_beats.delete();
      if (func == FUNC_ACK) begin
        // cumulative ack: advance base, drag next along if it falls behind
        acked = 0;
        if (!finished && ok && ack > base_idx && ack <= frame_total) begin
          acked    = ack - base_idx;
          base_idx = ack;
          if (next_idx < base_idx) next_idx = base_idx;
        end
        emit_beat(KIND_STATUS, 0, acked);
      end else if (finished) begin
        emit_beat(KIND_STATUS, 0, 0);
      end else if (base_idx >= frame_total) begin
        finished = 1'b1;
        emit_beat(KIND_EOF, 0, 0);
      end else begin
        win = (win_cfg > GBN_MAX_WINDOW) ? GBN_MAX_WINDOW : win_cfg;
        if (timer < TIMER_SAT) timer++;
        // fill the window with new frames
        while (next_idx < base_idx + win && next_idx < frame_total) begin
          count_xmit();
          if (base_idx == next_idx) timer = 0;
          next_idx++;
          emit_beat(KIND_NEW, next_idx - 1, 0);
        end
        // timer expired: resend everything outstanding
        if (timer > timeout_ticks) begin
          if (touts < 16'hFFFF) touts++;
          timer = 0;
          for (int unsigned i = base_idx; i < next_idx; i++) begin
            count_xmit();
            emit_beat(KIND_RESEND, i, 0);
          end
        end
        if (run_beats.size() == 0) emit_beat(KIND_STATUS, 0, 0);
      end
      run_beats[run_beats.size() - 1].last = 1'b1;
      foreach (run_beats[i]) due_beats.insert(due_beats.size(), run_beats[i]);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (due_beats.size() == 0) begin
        $error("unexpected result beat: item_kind %0d frame_index %0d", got.kind, got.frame);
        failures++;
        return;
      end
      want = due_beats.pop_front();
      compare_field("item_kind", want.kind, got.kind);
      compare_field("frame_index", want.frame, got.frame);
      compare_field("window_base", want.base, got.base);
      compare_field("next_to_send", want.next, got.next);
      compare_field("newly_acked", want.acked, got.acked);
      compare_field("transmit_total", want.xmits, got.xmits);
      compare_field("timeout_total", want.touts, got.touts);
      compare_field("all_done", want.done, got.done);
      compare_field("last_of_run", want.last, got.last);
    endfunction
  endclass

endpackage

module go_back_n_sender_window_test;
  import gbn_pkg::*;
  import gbn_tb_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    steady;
  arq_window_tracker     tracker;

  int unsigned win_set[6]  = '{32, 1, 7, 0, 17, 63};
  int unsigned tout_set[6] = '{3, 0, 65535, 2, 5, 1};

  gbn_in_if  in_ch();
  gbn_out_if out_ch();

  go_back_n_sender_window dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always #1 clk = ~clk;

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  // Present one event beat and hold it until accepted
  task automatic drive_event(func_t func, logic [IDX_W-1:0] ack, logic ok);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= func;
    in_ch.ack_number   <= ack;
    in_ch.ack_check_ok <= ok;
    do @(posedge clk); while (!in_ch.ready);
    tracker.accept_event(func, ack, ok);
  endtask

  task automatic tick();
    drive_event(FUNC_TICK, IDX_W'($urandom), 1'($urandom));
  endtask

  task automatic ack(int unsigned num, bit ok);
    drive_event(FUNC_ACK, IDX_W'(num), ok);
  endtask

  // Drop valid and wait for the block to drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.due_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(int unsigned win, int unsigned tout, int unsigned total);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_wdata <= CFG_DATA_W'(win);
    @(posedge clk);
    tracker.write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(win));
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= CFG_DATA_W'(tout);
    @(posedge clk);
    tracker.write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(tout));
    cfg_index <= CFG_FRAME_TOTAL;
    cfg_wdata <= CFG_DATA_W'(total);
    @(posedge clk);
    tracker.write_reg(CFG_FRAME_TOTAL, CFG_DATA_W'(total));
    cfg_we <= 1'b0;
  endtask

  // Ack somewhere in the outstanding range, sometimes a little past next
  function automatic int unsigned good_ack();
    int unsigned hi;
    hi = tracker.next_idx + 3;
    if (hi > tracker.frame_total) hi = tracker.frame_total;
    if (hi <= tracker.base_idx) return tracker.base_idx;
    return $urandom_range(tracker.base_idx + 1, hi);
  endfunction

  task automatic random_phase(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) tick();
      else if (pick < 86) ack(good_ack(), 1'b1);
      else if (pick < 92) ack(good_ack(), 1'b0);
      else if (pick < 97) ack($urandom_range(0, 65535), 1'b0);
      else ack($urandom_range(0, tracker.base_idx), 1'b1);
    end
  endtask

  // Check every accepted result beat
  always @(posedge clk) begin
    beat_t b;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      b.kind  = kind_t'(out_ch.item_kind);
      b.frame = out_ch.frame_index;
      b.base  = out_ch.window_base;
      b.next  = out_ch.next_to_send;
      b.acked = out_ch.newly_acked;
      b.xmits = out_ch.transmit_total;
      b.touts = out_ch.timeout_total;
      b.done  = out_ch.all_done;
      b.last  = out_ch.last_of_run;
      tracker.check_beat(b);
    end
  end

  // Result side backpressure
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    tracker = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_WINDOW_SIZE;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_TICK;
    in_ch.ack_number   <= '0;
    in_ch.ack_check_ok <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty transfer: every ack is out of range
    ack(65535, 1'b1);
    ack(0, 1'b1);
    ack(1, 1'b0);

    // window of one, immediate timeout
    configure(1, 0, 5);
    tick();
    tick();
    ack(1, 1'b1);
    ack(1, 1'b1);
    ack(6, 1'b1);
    ack(3, 1'b0);
    tick();
    ack(4, 1'b1);

    // zero window: timer still expires with nothing outstanding
    configure(0, 0, 5);
    tick();

    // oversized window clamps, longest timeout, largest transfer
    configure(63, 65535, 65535);
    tick();
    ack(20, 1'b1);
    tick();

    foreach (win_set[p]) begin
      configure(win_set[p], tout_set[p], 65535);
      steady = (p == 2 || p == 4);
      random_phase(35);
    end
    steady = 1'b0;

    // jump to the top of the index space, then finish the transfer
    configure(32, 4, 65535);
    ack(65530, 1'b1);
    tick();
    ack(65535, 1'b1);
    tick();
    tick();
    ack(65535, 1'b1);

    settle();
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
